@@ src/ctti_pkg.sv @@
// ============================================================================
// ctti_pkg
// Shared types and constants for the custom-alphabet text-to-integer parser.
// ============================================================================
package ctti_pkg;

    localparam int ALPHA_MAX   = 16;
    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CFG_W-1:0]  DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]  DIGITS_HIGH_RST = 64'h0;
    localparam logic [SIZE_W-1:0] ALPHA_SIZE_RST  = 5'd10;

    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SIZE  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    typedef struct packed {
        logic               digit_hit;
        logic [DIGIT_W-1:0] digit_val;
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               last;
        logic               alpha_ok;
        logic [SIZE_W-1:0]  base;
    } tok_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ src/custom_base_text_to_integer_top.sv @@
// ============================================================================
// custom_base_text_to_integer_top
// Text-to-integer parser over a configurable digit alphabet of 2 to 16 chars.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------
//  s_*      | in  | s_tvalid/s_tready  | text_byte, ends_text on tlast
//  m_*      | out | m_tvalid/m_tready  | parsed_value, alphabet_ok
//  cfg_*    | in  | cfg_valid/cfg_ready| register index, 64-bit data
//
// One byte per cycle sustained; a result is presented after its last byte is
// taken, classified into the queue and loaded by the parser into the result
// register. Two-entry queue decouples classifier and parser; a closing byte
// waits in it while a result is held, and input stalls only when it is full.
// Config is always ready. Reset returns the default alphabet.
// ============================================================================
module custom_base_text_to_integer_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ctti_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] text_byte
    input  logic                             s_tlast,   // ends_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ctti_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] parsed_value, [32] alphabet_ok
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ctti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctti_pkg::CFG_W-1:0]       cfg_data
);
    import ctti_pkg::*;

    tok_t front_tok;
    tok_t head_tok;
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    logic push;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;

    ctti_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_byte (s_tdata[BYTE_W-1:0]),
        .ends_text (s_tlast),
        .tok       (front_tok)
    );

    ctti_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (front_tok),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_tok  (head_tok)
    );

    ctti_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_not_empty),
        .tok       (head_tok),
        .tok_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ src/ctti_front.sv @@
// ============================================================================
// ctti_front
// Configuration registers, digit match and alphabet check for each byte.
// ============================================================================
module ctti_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [ctti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctti_pkg::CFG_W-1:0]      cfg_data,
    input  logic [ctti_pkg::BYTE_W-1:0]     text_byte,
    input  logic                            ends_text,
    output ctti_pkg::tok_t                  tok
);
    import ctti_pkg::*;

    logic [CFG_W-1:0]  digits_low_reg;
    logic [CFG_W-1:0]  digits_high_reg;
    logic [SIZE_W-1:0] alpha_size_reg;

    logic [BYTE_W-1:0] alpha [ALPHA_MAX];
    logic [ALPHA_MAX-1:0] in_use;
    logic [ALPHA_MAX-1:0] bad;
    logic               hit;
    logic [DIGIT_W-1:0] idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_low_reg  <= DIGITS_LOW_RST;
            digits_high_reg <= DIGITS_HIGH_RST;
            alpha_size_reg  <= ALPHA_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIGITS_LOW:  digits_low_reg  <= cfg_data;
                REG_DIGITS_HIGH: digits_high_reg <= cfg_data;
                REG_ALPHA_SIZE:  alpha_size_reg  <= cfg_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < ALPHA_MAX / 2; i++)
        begin
            alpha[i]                 = digits_low_reg[i*BYTE_W +: BYTE_W];
            alpha[i + ALPHA_MAX / 2] = digits_high_reg[i*BYTE_W +: BYTE_W];
        end
        for (int i = 0; i < ALPHA_MAX; i++)
            in_use[i] = (SIZE_W'(i) < alpha_size_reg);
    end

    // first matching in-use character
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = ALPHA_MAX - 1; i >= 0; i--)
        begin
            if (in_use[i] && (alpha[i] == text_byte))
            begin
                hit = 1'b1;
                idx = DIGIT_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ALPHA_MAX; i++)
        begin
            bad[i] = (alpha[i] == CH_NUL) || (alpha[i] == CH_PLUS)
                  || (alpha[i] == CH_MINUS) || is_ws(alpha[i]);
            for (int j = i + 1; j < ALPHA_MAX; j++)
                if (in_use[j] && (alpha[j] == alpha[i]))
                    bad[i] = 1'b1;
            bad[i] = bad[i] && in_use[i];
        end
    end

    always_comb
    begin
        tok.digit_hit = hit;
        tok.digit_val = idx;
        tok.is_space  = is_ws(text_byte);
        tok.is_plus   = (text_byte == CH_PLUS);
        tok.is_minus  = (text_byte == CH_MINUS);
        tok.last      = ends_text;
        tok.alpha_ok  = (alpha_size_reg >= SIZE_W'(2))
                     && (alpha_size_reg <= SIZE_W'(ALPHA_MAX)) && !(|bad);
        tok.base      = alpha_size_reg;
    end

endmodule

@@ src/ctti_queue.sv @@
// ============================================================================
// ctti_queue
// Two-entry word queue between the classifier and the parser.
// ============================================================================
module ctti_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctti_pkg::tok_t push_tok,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ctti_pkg::tok_t head_tok
);
    import ctti_pkg::*;

    tok_t               mem [QDEPTH];
    logic [QPTR_W-1:0]  head_reg;
    logic [QPTR_W-1:0]  head_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic [QPTR_W-1:0]  wr_ptr;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_tok  = mem[head_reg];
    assign wr_ptr    = head_reg + count_reg[QPTR_W-1:0];

    always_comb
    begin
        head_next  = pop ? head_reg + QPTR_W'(1) : head_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/ctti_back.sv @@
// ============================================================================
// ctti_back
// Parse state machine, accumulator and result register.
// ============================================================================
module ctti_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tok_valid,
    input  ctti_pkg::tok_t                   tok,
    output logic                             tok_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ctti_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ctti_pkg::*;

    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic                neg_reg;
    logic                neg_next;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [1:0]          ph;
    logic                ng;
    logic [VALUE_W-1:0]  ac;
    logic [VALUE_W-1:0]  res;

    // only a closing word needs the result register
    assign tok_pop  = tok_valid && (!tok.last || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        ph  = phase_reg;
        ng  = neg_reg;
        ac  = acc_reg;
        res = '0;

        if ((ph == PH_SPACE) && !tok.is_space)
            ph = PH_SIGN;

        if (ph == PH_SIGN)
        begin
            if (tok.digit_hit)
                ph = PH_DIGIT;
            else if (tok.is_minus)
                ng = !ng;
            else if (!tok.is_plus)
            begin
                ac = '0;
                ng = 1'b0;
                ph = PH_STOP;
            end
        end

        if (ph == PH_DIGIT)
        begin
            if (tok.digit_hit)
                ac = VALUE_W'(ac * {{(VALUE_W-SIZE_W){1'b0}}, tok.base})
                   + {{(VALUE_W-DIGIT_W){1'b0}}, tok.digit_val};
            else
                ph = PH_STOP;
        end

        if (tok.alpha_ok && ((ph == PH_DIGIT) || (ph == PH_STOP)))
            res = ng ? (VALUE_W'(0) - ac) : ac;

        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (tok_pop)
        begin
            if (tok.last)
            begin
                phase_next     = PH_SPACE;
                neg_next       = 1'b0;
                acc_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = {{(OUT_DATA_W-VALUE_W-1){1'b0}}, tok.alpha_ok, res};
            end
            else
            begin
                phase_next = ph;
                neg_next   = ng;
                acc_next   = ac;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ dv/custom_base_text_to_integer_top_test.sv @@
// ============================================================================
// custom_base_text_to_integer_top_test
// Self-checking bench for the custom-alphabet text-to-integer parser. Text
// words are fed from a queue with random gaps. Results are drained with random
// back-pressure and checked in order against a predictor kept in step with
// every accepted word. The alphabet is reprogrammed between phases while idle:
// valid, spoilt, out-of-range sizes and extreme register values.
// ============================================================================
module custom_base_text_to_integer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ctti_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 66;
    localparam int DRAIN_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PRINT_CAP       = 50;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } text_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } parse_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // predictor copy of the registers and parser state
    logic [CFG_W-1:0]       cur_lo     = DIGITS_LOW_RST;
    logic [CFG_W-1:0]       cur_hi     = DIGITS_HIGH_RST;
    logic [SIZE_W-1:0]      cur_size   = ALPHA_SIZE_RST;
    logic [1:0]             parse_ph   = PH_SPACE;
    logic                   parse_neg  = 1'b0;
    logic [VALUE_W-1:0]     parse_acc  = '0;

    text_word_t             text_words[$];
    parse_result_t          predicted_results[$];
    text_word_t             next_word;
    parse_result_t          oldest;
    int                     words_in_flight = 0;
    int                     mismatches      = 0;
    int                     stall_pct       = 20;
    int                     send_hold       = 0;
    int                     recv_hold       = 0;
    int                     quiet_cycles    = 0;

    custom_base_text_to_integer_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] alpha_char(int k);
        return (k < 8) ? cur_lo[8*k +: 8] : cur_hi[8*(k-8) +: 8];
    endfunction

    function automatic bit is_blank(logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int digit_of(logic [BYTE_W-1:0] c);
        int span;
        span = (cur_size > ALPHA_MAX) ? ALPHA_MAX : int'(cur_size);
        for (int k = 0; k < span; k++)
        begin
            if (alpha_char(k) == c)
                return k;
        end
        return -1;
    endfunction

    function automatic bit alphabet_sound();
        logic [BYTE_W-1:0] c;
        if (cur_size < 2 || cur_size > ALPHA_MAX)
            return 1'b0;
        for (int i = 0; i < cur_size; i++)
        begin
            c = alpha_char(i);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS || is_blank(c))
                return 1'b0;
            for (int j = i + 1; j < cur_size; j++)
            begin
                if (alpha_char(j) == c)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic parse_word(logic [BYTE_W-1:0] c, logic last);
        int            d;
        parse_result_t r;
        d = digit_of(c);
        if (parse_ph == PH_SPACE && !is_blank(c))
            parse_ph = PH_SIGN;
        if (parse_ph == PH_SIGN)
        begin
            if (d >= 0)
                parse_ph = PH_DIGIT;
            else if (c == CH_MINUS)
                parse_neg = ~parse_neg;
            else if (c != CH_PLUS)
            begin
                parse_acc = '0;
                parse_neg = 1'b0;
                parse_ph  = PH_STOP;
            end
        end
        if (parse_ph == PH_DIGIT)
        begin
            if (d >= 0)
                parse_acc = parse_acc * VALUE_W'(cur_size) + VALUE_W'(d);
            else
                parse_ph = PH_STOP;
        end
        if (last)
        begin
            r.ok    = alphabet_sound();
            r.value = '0;
            if (r.ok && (parse_ph == PH_DIGIT || parse_ph == PH_STOP))
                r.value = parse_neg ? (VALUE_W'(0) - parse_acc) : parse_acc;
            predicted_results.push_back(r);
            parse_ph  = PH_SPACE;
            parse_neg = 1'b0;
            parse_acc = '0;
        end
    endtask

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(99) >= stall_pct)
            return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_word(s_tdata[BYTE_W-1:0], s_tlast);
                words_in_flight--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (text_words.size() != 0)
                begin
                    next_word = text_words.pop_front();
                    send_hold = pick_gap();
                    s_tdata  <= next_word.ch;
                    s_tlast  <= next_word.last;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("unpredicted result", m_tdata[VALUE_W-1:0], '0);
                else
                begin
                    oldest = predicted_results.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== oldest.value)
                        report_mismatch("parsed_value", m_tdata[VALUE_W-1:0], oldest.value);
                    if (m_tdata[VALUE_W] !== oldest.ok)
                        report_mismatch("alphabet_ok", VALUE_W'(m_tdata[VALUE_W]),
                                        VALUE_W'(oldest.ok));
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                recv_hold = pick_gap();
                m_tready <= (recv_hold == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("custom_base_text_to_integer_top regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_word(logic [BYTE_W-1:0] ch, logic last);
        text_words.push_back('{ch: ch, last: last});
        words_in_flight++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], i == s.len() - 1);
    endtask

    function automatic logic [BYTE_W-1:0] random_blank();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + BYTE_W'(k);
    endfunction

    // mostly well-formed numbers, some noise and stray bytes
    task automatic queue_random_text(output int n_words);
        logic [BYTE_W-1:0] word_q[$];
        int                span;
        span = (cur_size > ALPHA_MAX) ? ALPHA_MAX : int'(cur_size);
        if (span == 0 || $urandom_range(9) < 2)
        begin
            repeat ($urandom_range(6, 1))
                word_q.push_back(BYTE_W'($urandom));
        end
        else
        begin
            repeat ($urandom_range(3))
                word_q.push_back(random_blank());
            repeat ($urandom_range(3))
                word_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            if ($urandom_range(7) == 0)
                word_q.push_back(BYTE_W'($urandom));
            repeat (($urandom_range(3) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1))
                word_q.push_back(alpha_char($urandom_range(span - 1)));
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(3, 1))
                    word_q.push_back(BYTE_W'($urandom));
            end
        end
        foreach (word_q[i])
            add_word(word_q[i], i == word_q.size() - 1);
        n_words = word_q.size();
    endtask

    function automatic logic [127:0] random_alphabet();
        logic [127:0]      a;
        bit [255:0]        taken;
        logic [BYTE_W-1:0] c;
        taken = '0;
        a     = '0;
        for (int k = 0; k < ALPHA_MAX; k++)
        begin
            do
                c = BYTE_W'($urandom);
            while (taken[c] || c == CH_NUL || c == CH_PLUS || c == CH_MINUS || is_blank(c));
            taken[c]    = 1'b1;
            a[8*k +: 8] = c;
        end
        return a;
    endfunction

    // one in-use character made illegal
    function automatic logic [127:0] spoil_alphabet(logic [127:0] a, int size);
        int pos;
        pos = $urandom_range(size - 1);
        case ($urandom_range(4))
            0:       a[8*pos +: 8] = a[8*((pos + 1) % size) +: 8];
            1:       a[8*pos +: 8] = CH_PLUS;
            2:       a[8*pos +: 8] = CH_MINUS;
            3:       a[8*pos +: 8] = random_blank();
            default: a[8*pos +: 8] = CH_NUL;
        endcase
        return a;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DIGITS_LOW:  cur_lo   = val;
            REG_DIGITS_HIGH: cur_hi   = val;
            REG_ALPHA_SIZE:  cur_size = val[SIZE_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic program_alphabet(logic [127:0] a, logic [SIZE_W-1:0] size);
        logic [CFG_W-1:0] size_word;
        size_word               = {$urandom, $urandom};
        size_word[SIZE_W-1:0]   = size;
        write_reg(REG_DIGITS_LOW, a[63:0]);
        write_reg(REG_DIGITS_HIGH, a[127:64]);
        write_reg(REG_ALPHA_SIZE, size_word);
    endtask

    // sender holds off until every result is back and the pipe has emptied
    task automatic settle();
        while (words_in_flight != 0 || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [127:0] alpha;
        int           size;
        int           n_words;
        int           added;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase_no = 0; phase_no < NUM_PHASES; phase_no++)
        begin
            settle();
            stall_pct = (phase_no % 3 == 2) ? 0 : 20;
            case (phase_no)
                1:  program_alphabet(random_alphabet(), 5'd2);
                2:  program_alphabet(random_alphabet(), 5'd16);
                3:
                begin
                    program_alphabet(random_alphabet(), SIZE_W'($urandom_range(15, 3)));
                    write_reg(REG_UNUSED, {$urandom, $urandom});
                end
                4:
                begin
                    alpha           = random_alphabet();
                    alpha[127:64]   = '1;
                    program_alphabet(alpha, 5'd9);
                end
                5, 8:
                begin
                    size = $urandom_range(16, 2);
                    program_alphabet(spoil_alphabet(random_alphabet(), size), SIZE_W'(size));
                end
                6:  program_alphabet({$urandom, $urandom, $urandom, $urandom}, 5'd0);
                7:  program_alphabet(random_alphabet(), 5'd31);
                9:  program_alphabet(random_alphabet(), 5'd1);
                10: program_alphabet({{CFG_W{1'b1}}, {CFG_W{1'b0}}}, 5'd16);
                11: program_alphabet({{CFG_W{1'b0}}, {CFG_W{1'b1}}}, 5'd2);
                default: ;
            endcase
            if (phase_no == 0)
            begin
                // reset alphabet leaves NUL in slots 8 and 9
                queue_text("-12");
                settle();
                write_reg(REG_DIGITS_HIGH, 64'h3938);
                queue_text("\011\012\013\014\015 +-5");
                queue_text("-3x9");
                queue_text("+ 7");
                queue_text(" -");
                add_word(8'hFF, 1'b1);
                add_word(CH_NUL, 1'b1);
                queue_text("0");
            end
            added = 0;
            while (added < WORDS_PER_PHASE)
            begin
                queue_random_text(n_words);
                added += n_words;
            end
        end
        settle();
        if (mismatches == 0)
            $display("custom_base_text_to_integer_top regression: pass");
        else
            $display("custom_base_text_to_integer_top regression: fail");
        $finish;
    end

endmodule

@@ custom_base_text_to_integer_top.f @@
src/ctti_pkg.sv
src/ctti_front.sv
src/ctti_queue.sv
src/ctti_back.sv
src/custom_base_text_to_integer_top.sv
dv/custom_base_text_to_integer_top_test.sv
